// ===== sv/hmmd_pkg.sv =====
// ----------------------------------------------------------------------------
// HMMD colour quantiser package
// Shared widths, constants and the divider payload type.
// ----------------------------------------------------------------------------
package hmmd_pkg;

	localparam int CHAN_W    = 8;
	localparam int X_W       = 11;              // k*diff - f lies in 0..6*255
	localparam int NUM_W     = 17;              // 85*x + diff stays below 2**17
	localparam int DEN_W     = CHAN_W + 1;      // 2*diff
	localparam int QUO_W     = 8;
	localparam int DIV_CELLS = QUO_W;           // one quotient bit per cell
	localparam int DIV_SHIFT = QUO_W - 1;
	localparam int BIN_W     = 6;

	localparam int HUE_SCALE = 85;

	localparam int K_RED_MIN   = 3;
	localparam int K_GREEN_MIN = 5;
	localparam int K_BLUE_MIN  = 1;

	localparam int BAND_SCALE   = 5;
	localparam int HUE_MID_DIVS = 6;
	localparam int SUM_MID_STEP = 6;

	localparam int BIN_BASE_LOW  = 8;
	localparam int BIN_BASE_MID  = 24;
	localparam int BIN_BASE_HIGH = 48;

	localparam logic [2:0] BAND_NEUTRAL = 3'd0;
	localparam logic [2:0] BAND_LOW     = 3'd1;
	localparam logic [2:0] BAND_MID     = 3'd2;
	localparam logic [2:0] BAND_HIGH    = 3'd3;
	localparam logic [2:0] BAND_MAX     = 3'd4;

	typedef struct packed {
		logic [NUM_W-1:0]  rem;
		logic [DEN_W-1:0]  den;
		logic [QUO_W-1:0]  quo;
		logic [CHAN_W-1:0] sum;
		logic [CHAN_W-1:0] diff;
	} hmmd_div_t;

endpackage

// ===== sv/hmmd_front.sv =====
// ----------------------------------------------------------------------------
// HMMD front end
// Finds max, min, diff and sum, forms the hue numerator and divisor.
// ----------------------------------------------------------------------------
module hmmd_front import hmmd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  logic [CHAN_W-1:0] red,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] blue,
	output logic              dn_valid,
	input  logic              dn_ready,
	output hmmd_div_t         dn_data
);

	logic [CHAN_W-1:0]      mx;
	logic [CHAN_W-1:0]      mn;
	logic [CHAN_W-1:0]      diff;
	logic [CHAN_W:0]        sum_full;
	logic [2:0]             k;
	logic signed [CHAN_W:0] f;
	logic [X_W-1:0]         kd;
	logic signed [X_W:0]    x_full;
	logic [X_W-1:0]         x;
	logic [NUM_W:0]         num_full;

	logic                   v_s1;
	logic [CHAN_W-1:0]      diff_s1;
	logic [CHAN_W-1:0]      sum_s1;
	logic [X_W-1:0]         x_s1;
	logic                   v_s2;
	hmmd_div_t              data_s2;

	logic                   en_s1;
	logic                   en_s2;

	assign en_s2    = !v_s2 || dn_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign up_ready = en_s1;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		diff     = mx - mn;
		sum_full = ({1'b0, mx} + {1'b0, mn} + 9'd1) >> 1;
		// The first channel equal to the minimum picks the hue sector.
		if (red == mn) begin
			k = 3'(K_RED_MIN);
			f = $signed({1'b0, green}) - $signed({1'b0, blue});
		end else if (green == mn) begin
			k = 3'(K_GREEN_MIN);
			f = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			k = 3'(K_BLUE_MIN);
			f = $signed({1'b0, red}) - $signed({1'b0, green});
		end
		kd     = X_W'(diff) * X_W'(k);
		x_full = $signed({1'b0, kd}) - $signed({{(X_W-CHAN_W){f[CHAN_W]}}, f});
		x      = x_full[X_W] ? '0 : x_full[X_W-1:0];
	end

	assign num_full = (NUM_W+1)'(x_s1) * (NUM_W+1)'(HUE_SCALE) + (NUM_W+1)'(diff_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= up_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && up_valid) begin
			diff_s1 <= diff;
			sum_s1  <= sum_full[CHAN_W-1:0];
			x_s1    <= x;
		end
		if (en_s2 && v_s1) begin
			data_s2.rem  <= num_full[NUM_W-1:0];
			data_s2.den  <= {diff_s1, 1'b0};
			data_s2.quo  <= '0;
			data_s2.sum  <= sum_s1;
			data_s2.diff <= diff_s1;
		end
	end

	assign dn_valid = v_s2;
	assign dn_data  = data_s2;

endmodule

// ===== sv/hmmd_div_cell.sv =====
// ----------------------------------------------------------------------------
// HMMD divider cell
// One restoring division step: settles one quotient bit per cell.
// ----------------------------------------------------------------------------
module hmmd_div_cell import hmmd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      up_valid,
	output logic      up_ready,
	input  hmmd_div_t up_data,
	output logic      dn_valid,
	input  logic      dn_ready,
	output hmmd_div_t dn_data
);

	logic             v_q;
	hmmd_div_t        data_q;
	logic [NUM_W-1:0] sub;
	logic [NUM_W-1:0] rem_next;
	logic             ge;
	logic             en;

	assign en       = !v_q || dn_ready;
	assign up_ready = en;

	// The partial remainder stays below 256 times the divisor, so comparing it
	// with 128 times the divisor decides the next quotient bit.
	always_comb begin
		sub      = NUM_W'({up_data.den, {DIV_SHIFT{1'b0}}});
		ge       = up_data.rem >= sub;
		rem_next = ge ? up_data.rem - sub : up_data.rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && up_valid) begin
			data_q.rem  <= {rem_next[NUM_W-2:0], 1'b0};
			data_q.den  <= up_data.den;
			data_q.quo  <= {up_data.quo[QUO_W-2:0], ge};
			data_q.sum  <= up_data.sum;
			data_q.diff <= up_data.diff;
		end
	end

	assign dn_valid = v_q;
	assign dn_data  = data_q;

endmodule

// ===== sv/hmmd_bin.sv =====
// ----------------------------------------------------------------------------
// HMMD bin mapper
// Picks the diff band, forms the 64-bin index and holds the result register.
// ----------------------------------------------------------------------------
module hmmd_bin import hmmd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  hmmd_div_t         up_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAN_W-1:0] hue_level,
	output logic [CHAN_W-1:0] sum_level,
	output logic [CHAN_W-1:0] diff_level,
	output logic [BIN_W-1:0]  bin_index
);

	logic [CHAN_W-1:0] hue;
	logic [10:0]       band_full;
	logic [2:0]        band;
	logic [10:0]       hue_mid_full;
	logic [2:0]        hue_mid;
	logic [1:0]        sum_hi;
	logic [1:0]        hue_hi;
	logic [BIN_W-1:0]  bin;

	logic              v_q;
	logic [CHAN_W-1:0] hue_q;
	logic [CHAN_W-1:0] sum_q;
	logic [CHAN_W-1:0] diff_q;
	logic [BIN_W-1:0]  bin_q;
	logic              en;

	assign en       = !v_q || out_ready;
	assign up_ready = en;

	always_comb begin
		// A grey pixel has a zero divisor; its hue is defined as zero.
		hue          = (up_data.diff == '0) ? '0 : up_data.quo;
		band_full    = 11'(up_data.diff) * 11'(BAND_SCALE);
		band         = band_full[10:8];
		hue_mid_full = 11'(hue) * 11'(HUE_MID_DIVS);
		hue_mid      = hue_mid_full[10:8];
		sum_hi       = up_data.sum[7:6];
		hue_hi       = hue[7:6];
		case (band) inside
			BAND_NEUTRAL: bin = BIN_W'(up_data.sum[7:5]);
			BAND_LOW:     bin = BIN_W'(BIN_BASE_LOW) + {2'b0, sum_hi, 2'b0}
			                    + BIN_W'(hue_hi);
			BAND_MID:     bin = BIN_W'(BIN_BASE_MID)
			                    + BIN_W'(sum_hi) * BIN_W'(SUM_MID_STEP)
			                    + BIN_W'(hue_mid);
			[BAND_HIGH:BAND_MAX]:
			              bin = BIN_W'(BIN_BASE_HIGH) + {2'b0, sum_hi, 2'b0}
			                    + BIN_W'(hue_hi);
			default:      bin = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && up_valid) begin
			hue_q  <= hue;
			sum_q  <= up_data.sum;
			diff_q <= up_data.diff;
			bin_q  <= bin;
		end
	end

	assign out_valid  = v_q;
	assign hue_level  = hue_q;
	assign sum_level  = sum_q;
	assign diff_level = diff_q;
	assign bin_index  = bin_q;

endmodule

// ===== sv/hmmd_color_quantizer.sv =====
// ----------------------------------------------------------------------------
// HMMD colour quantiser
// RGB pixel to HMMD hue, sum, diff and a 64-bin quantised index.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while the output side does not stall
// and returns exactly one result per pixel, in order. The hue division runs
// down a row of eight identical cells, one quotient bit per cell, between
// two front-end stages and the result register; every stage holds its own
// valid bit, so bubbles close up and new pixels are taken while a finished
// result waits on out_ready.
module hmmd_color_quantizer import hmmd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CHAN_W-1:0] red,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] blue,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAN_W-1:0] hue_level,
	output logic [CHAN_W-1:0] sum_level,
	output logic [CHAN_W-1:0] diff_level,
	output logic [BIN_W-1:0]  bin_index
);

	logic      chain_valid [DIV_CELLS+1];
	logic      chain_ready [DIV_CELLS+1];
	hmmd_div_t chain_data  [DIV_CELLS+1];

	hmmd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_valid),
		.up_ready (in_ready),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.dn_valid (chain_valid[0]),
		.dn_ready (chain_ready[0]),
		.dn_data  (chain_data[0])
	);

	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
		hmmd_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[i]),
			.up_ready (chain_ready[i]),
			.up_data  (chain_data[i]),
			.dn_valid (chain_valid[i+1]),
			.dn_ready (chain_ready[i+1]),
			.dn_data  (chain_data[i+1])
		);
	end

	hmmd_bin u_bin (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (chain_valid[DIV_CELLS]),
		.up_ready   (chain_ready[DIV_CELLS]),
		.up_data    (chain_data[DIV_CELLS]),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hue_level  (hue_level),
		.sum_level  (sum_level),
		.diff_level (diff_level),
		.bin_index  (bin_index)
	);

endmodule

// ===== sv/hmmd_checker.sv =====
// ----------------------------------------------------------------------------
// HMMD colour quantiser checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module hmmd_checker import hmmd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CHAN_W-1:0] hue_level,
	input logic [CHAN_W-1:0] sum_level,
	input logic [CHAN_W-1:0] diff_level,
	input logic [BIN_W-1:0]  bin_index
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	// A grey pixel carries zero hue.
	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && diff_level == '0 |-> hue_level == '0)
		else $error("non-zero hue for grey pixel");

	// In the lowest diff band the bin is the top three sum bits.
	a_neutral_bin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && diff_level < 8'd52 |-> bin_index == BIN_W'(sum_level[7:5]))
		else $error("wrong bin in neutral band");

	// Bins of saturated pixels start at the upper base.
	a_high_bin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && diff_level > 8'd153 |-> bin_index >= BIN_W'(BIN_BASE_HIGH))
		else $error("wrong bin in high band");

endmodule

bind hmmd_color_quantizer hmmd_checker u_hmmd_checker (.*);
